// File: src/cnfu_pkg.sv
// shared types, codes and helpers of the console number formatter
package cnfu_pkg;

    // request modes carried on the input tuser
    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_RAW  = 2'd1;
    localparam logic [1:0] MODE_DEC  = 2'd2;
    localparam logic [1:0] MODE_HEX  = 2'd3;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned DIGITS   = 10;
    localparam int unsigned NIBBLES  = 8;

    localparam logic [3:0] IDX_FINAL = 4'd9;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;

    typedef logic [3:0] t_digit;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic set_lead;
        logic emit;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic conv_last;
        logic char_last;
        logic out_free;
    } t_status;

    // one nibble as a lower-case hex character
    function automatic logic [7:0] hex_char(input t_digit nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = CH_ZERO + {4'd0, nib};
        end else begin
            ch = CH_A + {4'd0, nib} - 8'd10;
        end
        return ch;
    endfunction

endpackage

// File: src/cnfu_ctrl.sv
// sequencing state machine of the console number formatter
module cnfu_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_fire,
    input  logic [1:0]         i_mode,
    input  cnfu_pkg::t_status  i_status,
    output logic               o_in_ready,
    output cnfu_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_LEAD = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_mode == cnfu_pkg::MODE_DEC) ? ST_CONV : ST_EMIT;
                end
            end
            ST_CONV: begin
                o_cmd.step = 1'b1;
                if (i_status.conv_last) begin
                    n_state = ST_LEAD;
                end
            end
            ST_LEAD: begin
                o_cmd.set_lead = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.char_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: src/cnfu_datapath.sv
// conversion registers, character select and output register
module cnfu_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cnfu_pkg::t_cmd    i_cmd,
    input  logic [1:0]        i_mode,
    input  logic [31:0]       i_value,
    input  logic              i_out_ready,
    output cnfu_pkg::t_status o_status,
    output logic              o_out_valid,
    output logic [7:0]        o_out_char,
    output logic              o_out_last
);

    logic [1:0]                                    r_mode;
    logic [cnfu_pkg::VALUE_W-1:0]                  r_value;
    logic [cnfu_pkg::VALUE_W-1:0]                  r_shift;
    logic [cnfu_pkg::DIGITS-1:0][3:0]              r_bcd;
    logic [cnfu_pkg::DIGITS-1:0][3:0]              n_bcd;
    logic [4:0]                                    r_bit_cnt;
    logic [3:0]                                    r_idx;
    logic [3:0]                                    n_lead;
    logic [3:0]                                    pos;
    logic [cnfu_pkg::NIBBLES-1:0][3:0]             nibs;
    logic [7:0]                                    byte_in;
    logic                                          is_lf;
    logic [7:0]                                    cur_char;
    logic                                          cur_last;
    logic                                          r_out_valid;
    logic [7:0]                                    r_out_char;
    logic                                          r_out_last;

    // one double-dabble step: add three to digits of five or more, then shift
    always_comb begin
        logic [cnfu_pkg::DIGITS*4-1:0] adj;
        for (int i = 0; i < cnfu_pkg::DIGITS; i++) begin
            adj[4*i +: 4] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
        n_bcd = {adj[cnfu_pkg::DIGITS*4-2:0], r_shift[cnfu_pkg::VALUE_W-1]};
    end

    // count of leading zero digits, keeping at least the units digit
    always_comb begin
        n_lead = cnfu_pkg::IDX_FINAL;
        for (int p = 1; p < cnfu_pkg::DIGITS; p++) begin
            if (r_bcd[p] != 4'd0) begin
                n_lead = cnfu_pkg::IDX_FINAL - 4'(p);
            end
        end
    end

    // character for the current index
    assign pos     = cnfu_pkg::IDX_FINAL - r_idx;
    assign nibs    = r_value;
    assign byte_in = r_value[7:0];
    assign is_lf   = (byte_in == cnfu_pkg::CH_LF);

    always_comb begin
        cur_char = byte_in;
        cur_last = 1'b1;
        unique case (r_mode)
            cnfu_pkg::MODE_TEXT: begin
                cur_char = (is_lf && r_idx == 4'd0) ? cnfu_pkg::CH_CR : byte_in;
                cur_last = !is_lf || (r_idx == 4'd1);
            end
            cnfu_pkg::MODE_RAW: begin
                cur_char = byte_in;
                cur_last = 1'b1;
            end
            cnfu_pkg::MODE_DEC: begin
                cur_char = cnfu_pkg::CH_ZERO + {4'd0, r_bcd[pos]};
                cur_last = (r_idx == cnfu_pkg::IDX_FINAL);
            end
            cnfu_pkg::MODE_HEX: begin
                if (r_idx == 4'd0) begin
                    cur_char = cnfu_pkg::CH_ZERO;
                end else if (r_idx == 4'd1) begin
                    cur_char = cnfu_pkg::CH_X;
                end else begin
                    cur_char = cnfu_pkg::hex_char(nibs[pos[2:0]]);
                end
                cur_last = (r_idx == cnfu_pkg::IDX_FINAL);
            end
            default: begin
                cur_char = byte_in;
                cur_last = 1'b1;
            end
        endcase
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_value   <= i_value;
            r_shift   <= i_value;
            r_bcd     <= '0;
            r_bit_cnt <= '0;
            r_idx     <= '0;
        end else if (i_cmd.step) begin
            r_bcd     <= n_bcd;
            r_shift   <= {r_shift[cnfu_pkg::VALUE_W-2:0], 1'b0};
            r_bit_cnt <= r_bit_cnt + 5'd1;
        end else if (i_cmd.set_lead) begin
            r_idx     <= n_lead;
        end else if (i_cmd.emit) begin
            r_idx     <= r_idx + 4'd1;
        end
    end

    // output register, freed by a transfer on the master side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_char <= cur_char;
            r_out_last <= cur_last;
        end
    end

    // status back to the controller
    assign o_status.conv_last = (r_bit_cnt == 5'd31);
    assign o_status.char_last = cur_last;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

// File: src/console_number_formatter_unit.sv
// top level of the console number formatter: controller plus datapath
// decimal requests: load, shift-add-3 conversion of every value bit, leading-zero
// scan, then one character per cycle while the output is free
// other requests: one character per cycle after the accepting cycle, while the output is free
// one request at a time; the next is taken while the last character waits
// synchronous active-low reset empties the output register and idles the sequencer
module console_number_formatter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] char_out
    output logic        m_axis_tlast
);

    cnfu_pkg::t_cmd    cmd;
    cnfu_pkg::t_status status;
    logic              in_fire;

    // input transfer
    assign in_fire = s_axis_tvalid && s_axis_tready;

    cnfu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_mode     (s_axis_tuser),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    cnfu_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_mode      (s_axis_tuser),
        .i_value     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .o_out_char  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

// File: verif/console_number_formatter_unit_tb.sv
// self-checking testbench of the console number formatter: directed and random requests, character scoreboard

// expected character stream of the formatter and its comparison against the output
class console_char_scoreboard;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_exp;

    t_char_exp   expected_chars[$];
    int unsigned mismatch_count;

    function new();
        mismatch_count = 0;
    endfunction

    function int unsigned pending();
        return expected_chars.size();
    endfunction

    function void add_char(logic [7:0] ch, logic last);
        t_char_exp item;
        item.ch   = ch;
        item.last = last;
        expected_chars.push_back(item);
    endfunction

    function void flag_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endfunction

    // work out the characters an accepted request must produce
    function void note_request(logic [1:0] mode, logic [31:0] value);
        logic [7:0]  low_byte;
        logic [31:0] rest;
        logic [3:0]  dec_digits[10];
        logic [3:0]  nib;
        int          n;
        low_byte = value[7:0];
        case (mode)
            cnfu_pkg::MODE_TEXT: begin
                // line feed goes out as carriage return then line feed
                if (low_byte == cnfu_pkg::CH_LF) begin
                    add_char(cnfu_pkg::CH_CR, 1'b0);
                end
                add_char(low_byte, 1'b1);
            end
            cnfu_pkg::MODE_RAW: begin
                add_char(low_byte, 1'b1);
            end
            cnfu_pkg::MODE_DEC: begin
                // digits collected least significant first, sent most significant first
                rest = value;
                n    = 0;
                do begin
                    dec_digits[n] = 4'(rest % 32'd10);
                    rest          = rest / 32'd10;
                    n++;
                end while (rest != 32'd0);
                for (int k = n - 1; k >= 0; k--) begin
                    add_char(cnfu_pkg::CH_ZERO + {4'd0, dec_digits[k]}, k == 0);
                end
            end
            default: begin
                add_char(cnfu_pkg::CH_ZERO, 1'b0);
                add_char(cnfu_pkg::CH_X, 1'b0);
                for (int i = 0; i < 8; i++) begin
                    nib = value[28 - 4 * i +: 4];
                    if (nib < 4'd10) begin
                        add_char(cnfu_pkg::CH_ZERO + {4'd0, nib}, i == 7);
                    end else begin
                        add_char(cnfu_pkg::CH_A + {4'd0, nib} - 8'd10, i == 7);
                    end
                end
            end
        endcase
    endfunction

    // compare one output transfer with the oldest expected character
    function void check_char(logic [7:0] ch, logic last);
        t_char_exp item;
        if (expected_chars.size() == 0) begin
            flag_mismatch($sformatf("unexpected char 0x%02h last %0b", ch, last));
            return;
        end
        item = expected_chars.pop_front();
        if (item.ch !== ch) begin
            flag_mismatch($sformatf("char expected 0x%02h actual 0x%02h", item.ch, ch));
        end
        if (item.last !== last) begin
            flag_mismatch($sformatf("last expected %0b actual %0b (char 0x%02h)",
                                    item.last, last, ch));
        end
    endfunction

endclass

module console_number_formatter_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 80;
    localparam int unsigned IDLE_PCT     = 11;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] value
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] char_out
    logic        m_axis_tlast;

    console_char_scoreboard sb;
    logic        idle_en = 1'b1;
    int unsigned cycle_count = 0;

    console_number_formatter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // output side: check each transfer, then pick the ready for the next cycle
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                sb.check_char(m_axis_tdata, m_axis_tlast);
            end
            m_axis_tready <= idle_en ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
        end
    end

    // offer one request, with a random gap first while idling is enabled, and return at its transfer
    task automatic send_request(input logic [1:0] mode, input logic [31:0] value);
        while (idle_en && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= mode;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        sb.note_request(mode, value);
    endtask

    // stop offering and wait for every expected character
    task automatic drain_chars();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // value mix that reaches digit-count boundaries and line feeds often
    function automatic logic [31:0] pick_value();
        logic [31:0] pow10;
        int          e;
        pow10 = 32'd1;
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(0, 99);
            2: return {24'($urandom_range(0, 32'h00ff_ffff)), cnfu_pkg::CH_LF};
            3: begin
                e = $urandom_range(9);
                for (int k = 0; k < e; k++) begin
                    pow10 = pow10 * 32'd10;
                end
                return $urandom_range(1) ? pow10 : pow10 - 32'd1;
            end
            4: return $urandom_range(0, 255);
            default: return {1'b1, 31'($urandom)};
        endcase
    endfunction

    initial begin
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: character modes with line feed, byte extremes and upper bits set
        send_request(cnfu_pkg::MODE_TEXT, 32'h0000_0041);
        send_request(cnfu_pkg::MODE_TEXT, 32'h0000_000A);
        send_request(cnfu_pkg::MODE_TEXT, 32'hFFFF_FF0A);
        send_request(cnfu_pkg::MODE_TEXT, 32'h0000_0000);
        send_request(cnfu_pkg::MODE_TEXT, 32'hFFFF_FFFF);
        send_request(cnfu_pkg::MODE_TEXT, 32'h0000_000D);
        send_request(cnfu_pkg::MODE_RAW,  32'h0000_000A);
        send_request(cnfu_pkg::MODE_RAW,  32'hFFFF_FF0A);
        send_request(cnfu_pkg::MODE_RAW,  32'h0000_0000);
        send_request(cnfu_pkg::MODE_RAW,  32'hABCD_EFFF);
        // directed: decimal zero, digit-count edges and the full range
        send_request(cnfu_pkg::MODE_DEC,  32'd0);
        send_request(cnfu_pkg::MODE_DEC,  32'd9);
        send_request(cnfu_pkg::MODE_DEC,  32'd10);
        send_request(cnfu_pkg::MODE_DEC,  32'd999_999_999);
        send_request(cnfu_pkg::MODE_DEC,  32'd1_000_000_000);
        send_request(cnfu_pkg::MODE_DEC,  32'hFFFF_FFFF);
        send_request(cnfu_pkg::MODE_DEC,  32'h8000_0000);
        // directed: hex with leading zeros, all letters and all ones
        send_request(cnfu_pkg::MODE_HEX,  32'h0000_0000);
        send_request(cnfu_pkg::MODE_HEX,  32'hFFFF_FFFF);
        send_request(cnfu_pkg::MODE_HEX,  32'h0123_ABCD);
        send_request(cnfu_pkg::MODE_HEX,  32'h89AB_CDEF);

        // let the output empty completely before the random part
        drain_chars();

        // random requests, with no idling on either side for items 10 to 39
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_en = !(n >= 10 && n < 40);
            send_request(2'($urandom_range(3)), pick_value());
        end
        idle_en = 1'b1;

        drain_chars();
        repeat (60) @(posedge i_clk);

        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
